// ----- rtl/bpar_pkg.sv -----
// Package holding the item type and the AES-128 round functions for the address resolver.
`timescale 1ns / 1ps
`default_nettype none
package bpar_pkg;

   // Default depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;

   // Number of AES-128 rounds.
   localparam int ROUNDS = 10;

   // Top two address bits that mark a resolvable private address.
   localparam logic [1:0] RPA_TAG = 2'b01;

   // S-box, entry 0 in the top byte.
   localparam logic [2047:0] SBOX_TABLE = {
      128'h637c777bf26b6fc53001672bfed7ab76,
      128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115,
      128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84,
      128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8,
      128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973,
      128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479,
      128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
      128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df,
      128'h8ca1890dbfe6426841992d0fb054bb16
   };

   // One item as it travels from the front part to the back part.
   typedef struct packed {
      logic [127:0] key;
      logic [127:0] block;
      logic [23:0]  tag;
      logic         resolvable;
   } item_type;

   // S-box look-up for one byte.
   function automatic logic [7:0] sbox(input logic [7:0] b);
      return SBOX_TABLE[(11'd2047 - {b, 3'b000}) -: 8];
   endfunction

   // Round constant for a given round, 1 to 10.
   function automatic logic [7:0] rcon(input int round);
      logic [7:0] r;
      case (round)
         1: r = 8'h01;
         2: r = 8'h02;
         3: r = 8'h04;
         4: r = 8'h08;
         5: r = 8'h10;
         6: r = 8'h20;
         7: r = 8'h40;
         8: r = 8'h80;
         9: r = 8'h1b;
         10: r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // Multiplication by x in GF(2^8).
   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // SubBytes followed by ShiftRows; byte 0 sits in bits 127:120.
   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] o;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            o[127 - 8 * (r + 4 * c) -: 8] = sbox(s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]);
         end
      end
      return o;
   endfunction

   // MixColumns over the four columns.
   function automatic logic [127:0] mix_columns(input logic [127:0] s);
      logic [127:0] o;
      logic [7:0]   a0, a1, a2, a3, all;
      for (int c = 0; c < 4; c++) begin
         a0  = s[127 - 32 * c -: 8];
         a1  = s[119 - 32 * c -: 8];
         a2  = s[111 - 32 * c -: 8];
         a3  = s[103 - 32 * c -: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         o[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
         o[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
         o[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         o[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      return o;
   endfunction

   // One step of the key schedule, giving the next round key.
   function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage
`default_nettype wire

// ----- rtl/ble_private_address_resolver.sv -----
// Top level of the resolvable private address resolver.
// One request is taken per clock cycle while busy is low, and its result
// appears on the rsp_ ports for one cycle, strobed by rsp_valid, after
// passing through the front register, the queue and the AES pipeline (the
// initial key addition and ten rounds, each round including its
// key-schedule step). The AES pipeline accepts a new block every cycle, so
// the queue drains as fast as it fills and busy stays low in operation.
// There is no reset sweep.
`timescale 1ns / 1ps
`default_nettype none
module ble_private_address_resolver #(
   parameter int QueueDepth = bpar_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [47:0] req_address,
   input  wire logic [63:0] req_irk_low,
   input  wire logic [63:0] req_irk_high,
   output      logic        rsp_valid,
   output      logic        rsp_is_resolvable,
   output      logic [23:0] rsp_computed_hash,
   output      logic        rsp_match
);

   logic               accept;
   logic               front_valid;
   bpar_pkg::item_type front_item;
   logic               q_not_empty;
   logic               q_full;
   bpar_pkg::item_type q_item;

   assign accept = start && !busy;
   assign busy   = q_full;

   // Front part.
   bpar_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_address  (req_address),
      .req_irk_low  (req_irk_low),
      .req_irk_high (req_irk_high),
      .item_valid   (front_valid),
      .item         (front_item)
   );

   // Queue between the parts; the back part takes an item every cycle while the queue is not empty.
   bpar_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_item (front_item),
      .pop       (q_not_empty),
      .not_empty (q_not_empty),
      .full      (q_full),
      .pop_item  (q_item)
   );

   // Back part.
   bpar_back u_back (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (q_not_empty),
      .in_item           (q_item),
      .rsp_valid         (rsp_valid),
      .rsp_is_resolvable (rsp_is_resolvable),
      .rsp_computed_hash (rsp_computed_hash),
      .rsp_match         (rsp_match)
   );

endmodule
`default_nettype wire

// ----- rtl/bpar_front.sv -----
// Front part: registers an accepted request and classifies the address.
`timescale 1ns / 1ps
`default_nettype none
module bpar_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [47:0]         req_address,
   input  wire logic [63:0]         req_irk_low,
   input  wire logic [63:0]         req_irk_high,
   output      logic                item_valid,
   output      bpar_pkg::item_type  item
);

   logic               valid_ff;
   bpar_pkg::item_type item_ff;
   bpar_pkg::item_type item_in;

   // Build the key, the plaintext block and the address tag.
   always_comb begin
      item_in.key        = {req_irk_high, req_irk_low};
      item_in.block      = {104'd0, req_address[47:24]};
      item_in.tag        = req_address[23:0];
      item_in.resolvable = (req_address[47:46] == bpar_pkg::RPA_TAG);
   end

   // Control register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   // Payload register.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

// ----- rtl/bpar_queue.sv -----
// Short queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module bpar_queue #(
   parameter int Depth = bpar_pkg::QUEUE_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire bpar_pkg::item_type  push_item,
   input  wire logic                pop,
   output      logic                not_empty,
   output      logic                full,
   output      bpar_pkg::item_type  pop_item
);

   localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   bpar_pkg::item_type entry_ff [Depth];
   logic [IdxW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [IdxW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic               do_push, do_pop;

   assign do_push = push && !full;
   assign do_pop  = pop && not_empty;

   // Pointer and count updates, wrapping at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IdxW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IdxW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CntW'(Depth));
   assign pop_item  = entry_ff[rd_ptr_ff];

endmodule
`default_nettype wire

// ----- rtl/bpar_back.sv -----
// Back part: an AES-128 pipeline with one round per stage and the hash compare.
`timescale 1ns / 1ps
`default_nettype none
module bpar_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire bpar_pkg::item_type  in_item,
   output      logic                rsp_valid,
   output      logic                rsp_is_resolvable,
   output      logic [23:0]         rsp_computed_hash,
   output      logic                rsp_match
);

   localparam int Rounds = bpar_pkg::ROUNDS;

   logic         valid_ff [Rounds + 1];
   logic [127:0] state_ff [Rounds + 1];
   logic [127:0] key_ff   [Rounds + 1];
   logic [23:0]  tag_ff   [Rounds + 1];
   logic         res_ff   [Rounds + 1];
   logic         match_in;

   // Stage zero: initial key addition.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      state_ff[0] <= in_item.block ^ in_item.key;
      key_ff[0]   <= in_item.key;
      tag_ff[0]   <= in_item.tag;
      res_ff[0]   <= in_item.resolvable;
   end

   // One round per stage; the last round has no MixColumns.
   for (genvar g = 1; g <= Rounds; g++) begin : g_round
      logic [127:0] rkey;
      logic [127:0] sub;
      logic [127:0] mixed;

      assign rkey  = bpar_pkg::next_key(key_ff[g - 1], bpar_pkg::rcon(g));
      assign sub   = bpar_pkg::sub_shift(state_ff[g - 1]);
      assign mixed = (g == Rounds) ? sub : bpar_pkg::mix_columns(sub);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= valid_ff[g - 1];
         end
      end

      always_ff @(posedge clock) begin
         state_ff[g] <= mixed ^ rkey;
         key_ff[g]   <= rkey;
         tag_ff[g]   <= tag_ff[g - 1];
         res_ff[g]   <= res_ff[g - 1];
      end
   end

   // Compare the hash against the low address bits.
   assign match_in = res_ff[Rounds] && (state_ff[Rounds][23:0] == tag_ff[Rounds]);

   assign rsp_valid         = valid_ff[Rounds];
   assign rsp_is_resolvable = res_ff[Rounds];
   assign rsp_computed_hash = state_ff[Rounds][23:0];
   assign rsp_match         = match_in;

endmodule
`default_nettype wire

// ----- rtl/bpar_checker.sv -----
// Checker on the top-level ports of the resolver, with its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module bpar_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic        rsp_is_resolvable,
   input wire logic [23:0] rsp_computed_hash,
   input wire logic        rsp_match
);

   // The pipeline never stalls, so the block is never busy.
   assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("resolver reported busy");

   // Every transfer gives a result.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##13 rsp_valid)
      else $error("result missing after request transfer");

   // No result appears without a matching earlier transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 13))
      else $error("result without a matching request");

   // A match is only reported for a resolvable address.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_match) |-> rsp_is_resolvable)
      else $error("match on a non-resolvable address");

   // A result transfer carries known values on every field.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown({rsp_is_resolvable, rsp_computed_hash, rsp_match}))
      else $error("unknown value in a result transfer");

endmodule

bind ble_private_address_resolver bpar_checker u_bpar_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_is_resolvable (rsp_is_resolvable),
   .rsp_computed_hash (rsp_computed_hash),
   .rsp_match         (rsp_match)
);
`default_nettype wire
